FILE: src/rfd_pkg.sv
package rfd_pkg;

	// number of 16-bit channels carried by a channel frame
	localparam int CHANNELS = 10;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// depth of the command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// framing constants
	localparam logic [7:0] HEADER_BYTE = 8'hA0;
	localparam logic [7:0] ID_CHANNELS = 8'h01;
	localparam logic [7:0] ID_SETTINGS = 8'h0F;
	localparam logic [7:0] POS_LEN     = 8'd1;
	localparam logic [7:0] POS_ID      = 8'd2;
	localparam logic [7:0] POS_CH0     = 8'd3;
	localparam logic [7:0] MIN_LEN     = 8'd3;
	localparam logic [7:0] POS_CH_END  = 8'(3 + 2 * CHANNELS);

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SUM = 2'd1;
	localparam logic [1:0] ST_HDR = 2'd2;

	typedef logic [CHANNELS-1:0][15:0] rfd_chans_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rfd_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  frame_id;
		logic        channel_valid;
		logic [3:0]  channel_index;
		logic [15:0] channel_value;
		logic        send_ack;
		logic        last;
	} rfd_out_t;

	// one finished frame, as handed from front to back
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_id;
		logic       is_chan;
		logic       send_ack;
		rfd_chans_t chans;
	} rfd_cmd_t;

	// queue state seen by the two sides
	typedef struct packed {
		logic full;
		logic empty;
	} rfd_qstat_t;

endpackage

FILE: src/rfd_front.sv
module rfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_ready,
	input  rfd_pkg::rfd_in_t rx_data,
	input  rfd_pkg::rfd_qstat_t qstat,
	output logic             push,
	output rfd_pkg::rfd_cmd_t push_cmd
);
	import rfd_pkg::*;

	logic       in_frame_q;
	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] sum_q;
	logic       hdr_q;
	logic [7:0] id_q;
	rfd_chans_t stg_q;
	rfd_chans_t store_q;

	logic       accept;
	logic       start;
	logic       active;
	logic [7:0] b;
	logic [7:0] p;
	logic [7:0] off;
	logic [7:0] sum_c;
	logic [7:0] len_c;
	logic       hdr_c;
	logic [7:0] id_c;
	rfd_chans_t stg_c;
	logic       hdr_n;
	logic [7:0] len_n;
	logic [7:0] id_n;
	rfd_chans_t stg_n;
	logic       in_area;
	logic       fin;
	logic [1:0] st;
	logic       good_chan;

	assign rx_ready = !qstat.full;
	assign accept   = rx_valid && rx_ready;

	always_comb begin
		start  = rx_data.frame_start;
		b      = rx_data.rx_byte;
		active = start || in_frame_q;
		p      = start ? 8'd0 : pos_q;
		sum_c  = start ? 8'd0 : sum_q;
		len_c  = start ? 8'd0 : len_q;
		hdr_c  = start ? 1'b0 : hdr_q;
		id_c   = start ? 8'd0 : id_q;
		stg_c  = start ? store_q : stg_q;

		hdr_n = (p == 8'd0) ? (b == HEADER_BYTE) : hdr_c;
		len_n = (p == POS_LEN) ? b : len_c;
		id_n  = (p == POS_ID) ? b : id_c;

		// channel area: even offset is the high byte, odd the low byte
		off     = p - POS_CH0;
		in_area = (p >= POS_CH0) && (p < POS_CH_END);
		stg_n   = stg_c;
		for (int i = 0; i < CHANNELS; i++) begin
			if (in_area && (off[7:1] == 7'(i))) begin
				if (!off[0]) begin
					stg_n[i][15:8] = b;
				end else begin
					stg_n[i][7:0] = b;
				end
			end
		end

		// short length closes the frame on the id byte
		if (p < POS_ID) begin
			fin = 1'b0;
		end else if (len_n < MIN_LEN) begin
			fin = (p == POS_ID);
		end else begin
			fin = (p == (len_n - 8'd1));
		end

		if (!hdr_n) begin
			st = ST_HDR;
		end else if ((len_n < MIN_LEN) || (sum_c != b)) begin
			st = ST_SUM;
		end else begin
			st = ST_OK;
		end

		good_chan = (st == ST_OK) && (id_n == ID_CHANNELS);

		push_cmd.status   = st;
		push_cmd.frame_id = id_n;
		push_cmd.is_chan  = good_chan;
		push_cmd.send_ack = (st == ST_OK) && (id_n == ID_SETTINGS);
		push_cmd.chans    = stg_n;

		push = accept && active && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			hdr_q      <= 1'b0;
			id_q       <= '0;
			stg_q      <= '0;
			store_q    <= '0;
		end else if (accept && active) begin
			in_frame_q <= !fin;
			pos_q      <= p + 8'd1;
			sum_q      <= sum_c + b;
			len_q      <= len_n;
			hdr_q      <= hdr_n;
			id_q       <= id_n;
			stg_q      <= stg_n;
			if (fin && good_chan) begin
				store_q <= stg_n;
			end
		end
	end

endmodule

FILE: src/rfd_queue.sv
module rfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rfd_pkg::rfd_cmd_t   push_cmd,
	input  logic                pop,
	output rfd_pkg::rfd_cmd_t   pop_cmd,
	output rfd_pkg::rfd_qstat_t qstat
);
	import rfd_pkg::*;

	rfd_cmd_t           ent_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	logic do_push;
	logic do_pop;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_cmd     = ent_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
		logic [QPTR_W-1:0] nxt;
		if (ptr == QPTR_W'(QDEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/rfd_back.sv
module rfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rfd_pkg::rfd_qstat_t qstat,
	input  rfd_pkg::rfd_cmd_t   pop_cmd,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output rfd_pkg::rfd_out_t   res_data
);
	import rfd_pkg::*;

	rfd_cmd_t            cur_q;
	logic                busy_q;
	logic [CH_IDX_W-1:0] idx_q;

	logic is_last;
	logic done;

	assign is_last   = !cur_q.is_chan || (idx_q == CH_IDX_W'(CHANNELS - 1));
	assign res_valid = busy_q;
	assign done      = res_valid && res_ready && is_last;
	assign pop       = !qstat.empty && (!busy_q || done);

	always_comb begin
		res_data.status        = cur_q.status;
		res_data.frame_id      = cur_q.frame_id;
		res_data.channel_valid = cur_q.is_chan;
		res_data.channel_index = cur_q.is_chan ? 4'(idx_q) : 4'd0;
		res_data.channel_value = cur_q.is_chan ? cur_q.chans[idx_q] : 16'd0;
		res_data.send_ack      = cur_q.send_ack;
		res_data.last          = is_last;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (res_valid && res_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

FILE: src/remote_frame_deframer.sv
// Channel  Direction  Handshake              Payload
// rx       in         rx_valid / rx_ready    rx_data  (rfd_in_t: rx_byte, frame_start)
// res      out        res_valid / res_ready  res_data (rfd_out_t: status .. last)
//
// Each request (one link byte) is taken by the byte parser; the parser
// never waits on a frame's results unless the two-entry frame queue is full.
// A frame end gives one result, or CHANNELS results (one per cycle barring stalls) for a
// good channel frame, sent from the back end's output register as the queue drains.
// Reset clears all framing state and the channel store to zero.
// A stall on res holds the current result; rx_ready drops only when the queue fills.
module remote_frame_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  rfd_pkg::rfd_in_t  rx_data,
	output logic              res_valid,
	input  logic              res_ready,
	output rfd_pkg::rfd_out_t res_data
);
	import rfd_pkg::*;

	// front to queue
	logic       push;
	rfd_cmd_t   push_cmd;
	// queue to back
	logic       pop;
	rfd_cmd_t   pop_cmd;
	rfd_qstat_t qstat;

	// Front: tracks byte position, header, length, id and running sum, builds the
	// staged channel set, and at the closing byte pushes one frame command.
	rfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_data  (rx_data),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Frame commands carry a snapshot of the channels, so a later frame cannot
	// disturb a burst still being sent.
	rfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	// Back: turns one command into its run of results.
	rfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

`ifndef SYNTH
	// a full queue must hold off the byte side
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !rx_ready)
		else $error("rx_ready high with queue full");

	// a result that lacks last must be a channel of a burst
	a_mid_is_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.last) |-> res_data.channel_valid)
		else $error("non-final result without a channel");

	// decoded channels and acknowledges only come from good frames
	a_good_only: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_data.channel_valid || res_data.send_ack))
			|-> (res_data.status == ST_OK))
		else $error("channel or ack on a bad frame");

	// channel index steps by one within a burst
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res_data.channel_valid && !res_data.last)
			|=> (res_valid && (res_data.channel_index == $past(res_data.channel_index) + 4'd1)))
		else $error("channel index skipped");
`endif

endmodule
